### design/binary_min_heap_unit_defines.svh
// Assertion macros for the binary min-heap top module.
// Define NO_ASSERTIONS to compile every check away.
`ifndef BINARY_MIN_HEAP_UNIT_DEFINES_SVH
`define BINARY_MIN_HEAP_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// When the antecedent holds, the consequent holds in the same cycle.
`define BMH_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("binary min-heap check failed");
// When the antecedent holds, the consequent holds in the next cycle.
`define BMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("binary min-heap check failed");
`else
`define BMH_ASSERT_SAME(label, clk, rst, ante, cons)
`define BMH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### design/bmh_pkg.sv
`timescale 1ns / 1ps

package bmh_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = 11;
   localparam int KEY_W    = 32;
   // Wide enough to hold the right child index of the deepest entry.
   localparam int IDX_W    = ADDR_W + 2;

   typedef enum logic {
      OP_INSERT  = 1'b0,
      OP_EXTRACT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH,
      S_UP_RD,
      S_UP_CMP,
      S_DN_RD,
      S_DN_CMP,
      S_PLACE,
      S_RESP
   } state_type;

   typedef struct packed {
      logic accept;
      logic fetch;
      logic up_rd;
      logic up_cmp;
      logic dn_rd;
      logic dn_cmp;
      logic place;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic par_zero;
      logic up_less;
      logic dn_leaf;
      logic dn_less;
      logic rsp_free;
   } stat_type;

endpackage

### design/binary_min_heap_unit.sv
`timescale 1ns / 1ps
// Each sift level is a registered read, then a compare and write. A full insert, an empty
// extract, an insert into an empty heap and an extract that takes the last key need no sift;
// an insert climbs one level per parent compared, an extract descends from the root.
// One request at a time: the next can be taken in the cycle after the result loads.
// Synchronous active-high reset empties the heap and drops a pending result; the store is kept.
`include "binary_min_heap_unit_defines.svh"

module binary_min_heap_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic signed [bmh_pkg::KEY_W-1:0]  req_key,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [bmh_pkg::KEY_W-1:0]  rsp_min_key,
   output logic [1:0]                        rsp_status,
   output logic [bmh_pkg::CNT_W-1:0]         rsp_entry_count
);

   // The controller sequences each request through the sift loop; the datapath
   // holds the count, the moving key and its position, and the result register.
   bmh_pkg::cmd_type  cmd;
   bmh_pkg::stat_type stat;

   bmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_opcode(req_opcode),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The result register lets a new request enter while the last result waits.
   bmh_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_opcode     (req_opcode),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_min_key    (rsp_min_key),
      .rsp_status     (rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   // The block works on one request at a time.
   `BMH_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   // An empty extract returns a zero key and an empty heap.
   `BMH_ASSERT_SAME(a_empty_result, clock, reset,
      rsp_valid && (rsp_status == bmh_pkg::ST_EMPTY),
      (rsp_min_key == '0) && (rsp_entry_count == '0))
   // A refused insert only happens with the heap at capacity.
   `BMH_ASSERT_SAME(a_full_result, clock, reset,
      rsp_valid && (rsp_status == bmh_pkg::ST_FULL),
      rsp_entry_count == bmh_pkg::CNT_W'(bmh_pkg::CAPACITY))
   // The count never passes capacity.
   `BMH_ASSERT_SAME(a_count_bound, clock, reset, rsp_valid,
      rsp_entry_count <= bmh_pkg::CNT_W'(bmh_pkg::CAPACITY))

endmodule

### design/bmh_ram.sv
`timescale 1ns / 1ps

module bmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

### design/bmh_ctrl.sv
`timescale 1ns / 1ps

module bmh_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_opcode,
   output logic              req_ready,
   input  bmh_pkg::stat_type stat,
   output bmh_pkg::cmd_type  cmd
);

   bmh_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmh_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bmh_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_opcode == bmh_pkg::OP_INSERT) begin
                  if (stat.full) begin
                     state_in = bmh_pkg::S_RESP;
                  end else if (stat.empty) begin
                     state_in = bmh_pkg::S_PLACE;
                  end else begin
                     state_in = bmh_pkg::S_UP_RD;
                  end
               end else begin
                  state_in = stat.empty ? bmh_pkg::S_RESP : bmh_pkg::S_FETCH;
               end
            end
         end
         bmh_pkg::S_FETCH: begin
            // The count has already dropped; an empty heap needs no sift.
            state_in = stat.empty ? bmh_pkg::S_RESP : bmh_pkg::S_DN_RD;
         end
         bmh_pkg::S_UP_RD: begin
            state_in = bmh_pkg::S_UP_CMP;
         end
         bmh_pkg::S_UP_CMP: begin
            if (stat.up_less && !stat.par_zero) begin
               state_in = bmh_pkg::S_UP_RD;
            end else begin
               state_in = bmh_pkg::S_PLACE;
            end
         end
         bmh_pkg::S_DN_RD: begin
            state_in = stat.dn_leaf ? bmh_pkg::S_PLACE : bmh_pkg::S_DN_CMP;
         end
         bmh_pkg::S_DN_CMP: begin
            state_in = stat.dn_less ? bmh_pkg::S_DN_RD : bmh_pkg::S_PLACE;
         end
         bmh_pkg::S_PLACE: begin
            state_in = bmh_pkg::S_RESP;
         end
         bmh_pkg::S_RESP: begin
            if (stat.rsp_free) begin
               state_in = bmh_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bmh_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         bmh_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         bmh_pkg::S_FETCH:  cmd.fetch    = 1'b1;
         bmh_pkg::S_UP_RD:  cmd.up_rd    = 1'b1;
         bmh_pkg::S_UP_CMP: cmd.up_cmp   = 1'b1;
         bmh_pkg::S_DN_RD:  cmd.dn_rd    = !stat.dn_leaf;
         bmh_pkg::S_DN_CMP: cmd.dn_cmp   = 1'b1;
         bmh_pkg::S_PLACE:  cmd.place    = 1'b1;
         bmh_pkg::S_RESP:   cmd.rsp_load = stat.rsp_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

### design/bmh_datapath.sv
`timescale 1ns / 1ps

module bmh_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  bmh_pkg::cmd_type                  cmd,
   output bmh_pkg::stat_type                 stat,
   input  logic                              req_opcode,
   input  logic signed [bmh_pkg::KEY_W-1:0]  req_key,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [bmh_pkg::KEY_W-1:0]  rsp_min_key,
   output logic [1:0]                        rsp_status,
   output logic [bmh_pkg::CNT_W-1:0]         rsp_entry_count
);

   logic [bmh_pkg::CNT_W-1:0]        count_ff;
   logic [bmh_pkg::ADDR_W-1:0]       pos_ff;
   logic signed [bmh_pkg::KEY_W-1:0] key_ff;
   logic signed [bmh_pkg::KEY_W-1:0] min_ff;
   bmh_pkg::status_type              status_ff;
   logic                             rsp_valid_ff;
   logic signed [bmh_pkg::KEY_W-1:0] rsp_min_ff;
   logic [1:0]                       rsp_status_ff;
   logic [bmh_pkg::CNT_W-1:0]        rsp_count_ff;

   logic [bmh_pkg::ADDR_W-1:0] parent;
   logic [bmh_pkg::IDX_W-1:0]  left;
   logic [bmh_pkg::IDX_W-1:0]  right;
   logic [bmh_pkg::IDX_W-1:0]  count_ext;
   logic                       pick_right;
   logic [bmh_pkg::ADDR_W-1:0] pick_addr;
   logic signed [bmh_pkg::KEY_W-1:0] pick_val;

   logic                             wr_en;
   logic [bmh_pkg::ADDR_W-1:0]       wr_addr;
   logic [bmh_pkg::KEY_W-1:0]        wr_data;
   logic [bmh_pkg::ADDR_W-1:0]       rd_addr_a;
   logic [bmh_pkg::ADDR_W-1:0]       rd_addr_b;
   logic [bmh_pkg::KEY_W-1:0]        rd_data_a;
   logic [bmh_pkg::KEY_W-1:0]        rd_data_b;

   assign parent     = bmh_pkg::ADDR_W'((pos_ff - 1'b1) >> 1);
   assign left       = {1'b0, pos_ff, 1'b1};
   assign right      = left + 1'b1;
   assign count_ext  = bmh_pkg::IDX_W'(count_ff);
   // The left child wins ties; the right one only when strictly smaller.
   assign pick_right = (right < count_ext) && ($signed(rd_data_b) < $signed(rd_data_a));
   assign pick_addr  = pick_right ? right[bmh_pkg::ADDR_W-1:0] : left[bmh_pkg::ADDR_W-1:0];
   assign pick_val   = pick_right ? $signed(rd_data_b) : $signed(rd_data_a);

   assign stat.full     = (count_ff == bmh_pkg::CNT_W'(bmh_pkg::CAPACITY));
   assign stat.empty    = (count_ff == '0);
   assign stat.par_zero = (parent == '0);
   assign stat.up_less  = (key_ff < $signed(rd_data_a));
   assign stat.dn_leaf  = (left >= count_ext);
   assign stat.dn_less  = (pick_val < key_ff);
   assign stat.rsp_free = !rsp_valid_ff || rsp_ready;

   // Memory ports: the moving key stays in key_ff, so each level writes one entry.
   always_comb begin
      rd_addr_a = '0;
      rd_addr_b = '0;
      if (cmd.accept) begin
         rd_addr_b = bmh_pkg::ADDR_W'(count_ff - 1'b1);
      end else if (cmd.up_rd) begin
         rd_addr_a = parent;
      end else if (cmd.dn_rd) begin
         rd_addr_a = left[bmh_pkg::ADDR_W-1:0];
         rd_addr_b = right[bmh_pkg::ADDR_W-1:0];
      end
   end

   assign wr_en   = cmd.place || (cmd.up_cmp && stat.up_less) || (cmd.dn_cmp && stat.dn_less);
   assign wr_addr = pos_ff;
   assign wr_data = cmd.place ? key_ff : (cmd.up_cmp ? rd_data_a : pick_val);

   bmh_ram #(
      .WIDTH(bmh_pkg::KEY_W),
      .DEPTH(bmh_pkg::CAPACITY)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr_a(rd_addr_a),
      .rd_data_a(rd_data_a),
      .rd_addr_b(rd_addr_b),
      .rd_data_b(rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            if (req_opcode == bmh_pkg::OP_INSERT) begin
               if (!stat.full) begin
                  count_ff <= count_ff + 1'b1;
               end
            end else if (!stat.empty) begin
               count_ff <= count_ff - 1'b1;
            end
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         min_ff <= '0;
         key_ff <= req_key;
         pos_ff <= bmh_pkg::ADDR_W'(count_ff);
         if (req_opcode == bmh_pkg::OP_INSERT) begin
            status_ff <= stat.full ? bmh_pkg::ST_FULL : bmh_pkg::ST_OK;
         end else begin
            status_ff <= stat.empty ? bmh_pkg::ST_EMPTY : bmh_pkg::ST_OK;
         end
      end
      if (cmd.fetch) begin
         min_ff <= $signed(rd_data_a);
         key_ff <= $signed(rd_data_b);
         pos_ff <= '0;
      end
      if (cmd.up_cmp && stat.up_less) begin
         pos_ff <= parent;
      end
      if (cmd.dn_cmp && stat.dn_less) begin
         pos_ff <= pick_addr;
      end
      if (cmd.rsp_load) begin
         rsp_min_ff    <= min_ff;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_min_key     = rsp_min_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

### tb/tb_binary_min_heap_unit.sv
`timescale 1ns / 1ps

module tb_binary_min_heap_unit;
   import bmh_pkg::*;

   // Run length guard.
   localparam int CYCLE_LIMIT = 1_000_000;
   // Cycles to wait after the last response so that a stray extra response
   // still shows up.
   localparam int TAIL_CYCLES = 40;
   // The response side stops taking results for this long, twice.
   localparam int LONG_HOLD   = 300;
   localparam int HOLD_AT_A   = 20;
   localparam int HOLD_AT_B   = 500;
   localparam int MAX_REPORTS = 40;

   typedef struct {
      op_type                  op;
      logic signed [KEY_W-1:0] key;
      bit                      drain_first;
   } heap_request_type;

   typedef struct {
      logic signed [KEY_W-1:0] min_key;
      status_type              status;
      logic [CNT_W-1:0]        entry_count;
   } heap_result_type;

   logic                    clock;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_opcode = 1'b0;
   logic signed [KEY_W-1:0] req_key = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [KEY_W-1:0] rsp_min_key;
   logic [1:0]              rsp_status;
   logic [CNT_W-1:0]        rsp_entry_count;

   binary_min_heap_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_min_key     (rsp_min_key),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   // Requests waiting to be offered, and the results that accepted requests
   // are owed, oldest first.
   heap_request_type pending_requests[$];
   heap_result_type  owed_results[$];

   // Our own copy of the heap, advanced once per accepted request.
   logic signed [KEY_W-1:0] shadow_keys [CAPACITY];
   int unsigned             shadow_size = 0;

   // Entry count as the stimulus generator sees it, used only to shape the
   // request mix (fill to full, drain, and so on).
   int gen_count = 0;

   int error_count  = 0;
   int cycle_count  = 0;
   int sent_count   = 0;
   int rsp_seen     = 0;
   int tx_wait      = 0;
   int rx_wait      = 0;
   int hold_left    = 0;
   int holds_done   = 0;
   bit tx_quiet     = 1'b0;
   bit rx_quiet     = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // One line per mismatch; the printout is capped but every one is counted.
   task automatic report_mismatch(input string msg);
      if (error_count < MAX_REPORTS)
         $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   // Advances the shadow heap by one request and returns the result it owes.
   // Sift-up climbs while the new key is strictly below its parent. Sift-down
   // takes the smaller child (the left one on a tie) and moves only past a
   // strictly smaller key, so equal keys never trade places.
   function automatic heap_result_type heap_step(input op_type op,
                                                 input logic signed [KEY_W-1:0] key);
      heap_result_type         res;
      int unsigned             pos;
      int unsigned             par;
      int unsigned             left;
      int unsigned             right;
      int unsigned             pick;
      logic signed [KEY_W-1:0] tmp;
      res.min_key = '0;
      res.status  = ST_OK;
      if (op == OP_INSERT) begin
         if (shadow_size >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            shadow_keys[shadow_size] = key;
            pos = shadow_size;
            shadow_size++;
            while (pos > 0) begin
               par = (pos - 1) / 2;
               if (!(shadow_keys[pos] < shadow_keys[par]))
                  break;
               tmp               = shadow_keys[pos];
               shadow_keys[pos]  = shadow_keys[par];
               shadow_keys[par]  = tmp;
               pos = par;
            end
         end
      end else begin
         if (shadow_size == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.min_key = shadow_keys[0];
            shadow_size--;
            shadow_keys[0] = shadow_keys[shadow_size];
            pos = 0;
            forever begin
               left  = 2 * pos + 1;
               right = left + 1;
               if (left >= shadow_size)
                  break;
               pick = left;
               if (right < shadow_size && shadow_keys[right] < shadow_keys[left])
                  pick = right;
               if (!(shadow_keys[pick] < shadow_keys[pos]))
                  break;
               tmp               = shadow_keys[pos];
               shadow_keys[pos]  = shadow_keys[pick];
               shadow_keys[pick] = tmp;
               pos = pick;
            end
         end
      end
      res.entry_count = CNT_W'(shadow_size);
      return res;
   endfunction

   // Idle length between requests or between taken responses: mostly none
   // or short, now and then a long one.
   function automatic int idle_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   // Keys lean toward small values (to get plenty of duplicates and ties
   // between children) and toward the ends of the signed range.
   function automatic logic signed [KEY_W-1:0] random_key();
      int         r;
      logic [15:0] half;
      r    = $urandom_range(0, 9);
      half = 16'($urandom);
      case (r)
         0, 1, 2, 3: return KEY_W'($urandom);
         4, 5, 6:    return KEY_W'(int'($urandom_range(0, 7)) - 4);
         7: begin
            case ($urandom_range(0, 3))
               0:       return 32'sh8000_0000;
               1:       return 32'sh7FFF_FFFF;
               2:       return '0;
               default: return '1;
            endcase
         end
         8: begin
            if ($urandom_range(0, 1) == 0)
               return 32'sh8000_0000 + KEY_W'($urandom_range(0, 3));
            return 32'sh7FFF_FFFF - KEY_W'($urandom_range(0, 3));
         end
         default: return {{16{half[15]}}, half};
      endcase
   endfunction

   task automatic add_request(input op_type op, input logic signed [KEY_W-1:0] key,
                              input bit drain_first);
      heap_request_type item;
      item.op          = op;
      item.key         = key;
      item.drain_first = drain_first;
      pending_requests.insert(pending_requests.size(), item);
      if (op == OP_INSERT) begin
         if (gen_count < CAPACITY)
            gen_count++;
      end else if (gen_count > 0) begin
         gen_count--;
      end
   endtask

   // Request driver. A request is presented with valid held steady until the
   // block takes it; the prediction is made at the edge of acceptance. After
   // each request a random idle stretch follows unless the sender is in a
   // quiet (back-to-back) spell. A request flagged drain_first is held back
   // until every accepted request has been answered.
   always @(posedge clock) begin : request_driver
      heap_request_type item;
      heap_result_type  owed;
      if (reset) begin
         req_valid  <= 1'b0;
         req_opcode <= OP_INSERT;
         req_key    <= '0;
         tx_wait    <= 0;
      end else begin
         if (req_valid && req_ready) begin
            owed = heap_step(op_type'(req_opcode), req_key);
            owed_results.insert(owed_results.size(), owed);
            sent_count++;
         end
         if (req_valid && !req_ready) begin
            // Still waiting on the block: keep the request as it is.
         end else if (tx_wait > 0) begin
            tx_wait   <= tx_wait - 1;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0 &&
                      (!pending_requests[0].drain_first || sent_count == rsp_seen)) begin
            item = pending_requests.pop_front();
            req_valid  <= 1'b1;
            req_opcode <= item.op;
            req_key    <= item.key;
            if ($urandom_range(0, 59) == 0)
               tx_quiet = ~tx_quiet;
            tx_wait <= tx_quiet ? 0 : idle_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Long response stalls, counted here on their own. While one lasts the
   // sender keeps offering, so the block stalls with a result waiting and drops req_ready.
   always @(posedge clock) begin : response_hold
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if ((holds_done == 0 && rsp_seen >= HOLD_AT_A) ||
                   (holds_done == 1 && rsp_seen >= HOLD_AT_B)) begin
         hold_left  <= LONG_HOLD;
         holds_done <= holds_done + 1;
      end
   end

   // Response ready: after each taken response it may drop for a random
   // stretch, and it stays low during a long hold.
   always @(posedge clock) begin : response_ready_ctl
      int w;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait   <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if ($urandom_range(0, 49) == 0)
               rx_quiet = ~rx_quiet;
            w = rx_quiet ? 0 : idle_gap();
         end else if (rx_wait > 0) begin
            w = rx_wait - 1;
         end else begin
            w = 0;
         end
         rx_wait   <= w;
         rsp_ready <= (w == 0) && (hold_left == 0);
      end
   end

   // Response checker: every taken response is matched against the oldest
   // owed result, field by field.
   always @(posedge clock) begin : result_monitor
      heap_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_seen <= rsp_seen + 1;
         if (owed_results.size() == 0) begin
            report_mismatch($sformatf("response with no request outstanding (key %0d)",
                                      rsp_min_key));
         end else begin
            want = owed_results.pop_front();
            if (rsp_min_key !== want.min_key)
               report_mismatch($sformatf("response %0d: min_key %0d, wanted %0d",
                                         rsp_seen, rsp_min_key, want.min_key));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("response %0d: status %0d, wanted %s",
                                         rsp_seen, rsp_status, want.status.name()));
            if (rsp_entry_count !== want.entry_count)
               report_mismatch($sformatf("response %0d: entry_count %0d, wanted %0d",
                                         rsp_seen, rsp_entry_count, want.entry_count));
         end
      end
   end

   always @(posedge clock) begin : run_guard
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus_and_end
      int i;
      op_type op;

      // Directed opening: extract on an empty heap, keys at both ends of the
      // signed range, duplicate keys, a full drain followed by one more
      // extract on empty, and extracts that carry nonzero (ignored) keys.
      add_request(OP_EXTRACT, KEY_W'($urandom), 1'b0);
      add_request(OP_INSERT, 32'sh7FFF_FFFF, 1'b0);
      add_request(OP_INSERT, 32'sh8000_0000, 1'b0);
      add_request(OP_INSERT, 32'sh0000_0000, 1'b0);
      add_request(OP_INSERT, 32'shFFFF_FFFF, 1'b0);
      add_request(OP_INSERT, 32'sh0000_0001, 1'b0);
      add_request(OP_EXTRACT, '1, 1'b0);
      add_request(OP_EXTRACT, 32'sh5555_5555, 1'b0);
      add_request(OP_INSERT, 32'sd5, 1'b0);
      add_request(OP_INSERT, 32'sd5, 1'b0);
      add_request(OP_INSERT, 32'sd5, 1'b0);
      add_request(OP_INSERT, 32'sd3, 1'b0);
      add_request(OP_INSERT, 32'sd5, 1'b0);
      for (i = 0; i < 9; i++)
         add_request(OP_EXTRACT, KEY_W'($urandom), 1'b0);
      add_request(OP_INSERT, 32'sh5555_5555, 1'b0);
      add_request(OP_INSERT, 32'shAAAA_AAAA, 1'b0);
      add_request(OP_EXTRACT, 32'shAAAA_AAAA, 1'b0);
      add_request(OP_EXTRACT, '0, 1'b0);

      // Random mix on a small heap, including the odd extract on empty.
      for (i = 0; i < 60; i++) begin
         op = ($urandom_range(0, 99) < 55) ? OP_INSERT : OP_EXTRACT;
         add_request(op, random_key(), 1'b0);
      end

      // Fill to capacity with random keys (an occasional extract mixed in),
      // starting only once the block has answered everything so far.
      add_request(OP_INSERT, random_key(), 1'b1);
      while (gen_count < CAPACITY) begin
         op = ($urandom_range(0, 39) == 0) ? OP_EXTRACT : OP_INSERT;
         add_request(op, random_key(), 1'b0);
      end

      // Inserts into a full heap are refused.
      for (i = 0; i < 4; i++)
         add_request(OP_INSERT, random_key(), 1'b0);

      // Churn at the top of the range, then a run of deep extracts.
      for (i = 0; i < 40; i++) begin
         op = ($urandom_range(0, 99) < 50) ? OP_INSERT : OP_EXTRACT;
         add_request(op, random_key(), 1'b0);
      end
      for (i = 0; i < 40; i++)
         add_request(OP_EXTRACT, random_key(), 1'b0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Wait for every request to be taken and answered, then a little more
      // to catch any response that should not be there.
      while (pending_requests.size() != 0 || req_valid || sent_count != rsp_seen)
         @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      if (owed_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", owed_results.size()));

      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
